// ===== rtl/lsc_pkg.sv =====
// Shared types and constants for the LIFO stack with peek and change.
// No dependencies; every other file in rtl/ imports this package.
package lsc_pkg;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;

    // Operation codes carried on the request channel
    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_DUMP   = 3'd2,
        OP_PEEK   = 3'd3,
        OP_CHANGE = 3'd4
    } op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADPOS   = 2'd3
    } status_t;

    // What every cell of the chain does in a cycle
    typedef enum logic [2:0] {
        CELL_HOLD   = 3'd0,
        CELL_PUSH   = 3'd1,
        CELL_POP    = 3'd2,
        CELL_ROTATE = 3'd3,
        CELL_WRITE  = 3'd4
    } cell_cmd_t;

    // Control broadcast from the top level to all cells
    typedef struct packed {
        cell_cmd_t        cmd;
        logic [POS_W-1:0] position;
        logic [POS_W-1:0] wrap_idx;
    } cell_ctl_t;

endpackage

// ===== rtl/lsc_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
// Depends on lsc_pkg for field widths.
interface lsc_req_if
    import lsc_pkg::*;
    (
    );
    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output op, output value, output position, input ready);
    modport sink   (input valid, input op, input value, input position, output ready);
endinterface

interface lsc_rsp_if
    import lsc_pkg::*;
    (
    );
    logic                     valid;
    logic                     ready;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic                     last;

    modport source (output valid, output status, output data, output last, input ready);
    modport sink   (input valid, input status, input data, input last, output ready);
endinterface

// ===== rtl/lifo_stack_with_peek_change.sv =====
// Bounded LIFO stack of signed 32-bit words, built as a chain of DEPTH cells with the top
// word in the first cell. Push, pop, peek and change finish when taken, so a new request
// beat is taken every cycle while the response register drains. A dump of n stored words
// sends n response beats, one per cycle while the response is not stalled, and holds off
// requests until the last beat: the chain rotates by one cell per beat and is back in its
// original order after the last one. Empty stacks, full stacks and bad positions answer
// with a single status beat. Op codes 5 to 7 are taken and dropped with no response. No
// clearing pass is needed after reset. Depends on lsc_pkg, lsc_if and lsc_cell.
module lifo_stack_with_peek_change
    import lsc_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic    clk,
    input  logic    rst_n,
    lsc_req_if.sink   req,
    lsc_rsp_if.source rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     remain_reg, remain_next;

    logic                     out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]      out_status_reg, out_status_next;
    logic signed [DATA_W-1:0] out_data_reg, out_data_next;
    logic                     out_last_reg, out_last_next;

    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] cell_word [DEPTH];
    logic signed [DATA_W-1:0] cell_peek [DEPTH];
    logic signed [DATA_W-1:0] peek_data;
    logic                     out_free;
    logic                     accept;
    logic                     emit;
    logic                     bad_pos;
    logic [POS_W-1:0]         count_ext;

    // Handshake
    assign out_free  = !out_valid_reg || rsp.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;
    assign accept    = req.valid && req.ready;

    assign count_ext = POS_W'(count_reg);
    assign bad_pos   = (req.position == '0) || (req.position > count_ext);

    // Gather the word at the requested position
    always_comb
    begin
        peek_data = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            peek_data = peek_data | cell_peek[i];
        end
    end

    // Decode the request or advance a dump run
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        remain_next     = remain_reg;
        emit            = 1'b0;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        ctl.cmd         = CELL_HOLD;
        ctl.position    = req.position;
        ctl.wrap_idx    = count_ext - POS_W'(1);

        priority if (accept)
        begin
            out_last_next = 1'b1;
            out_data_next = '0;
            if (req.op == OP_PUSH)
            begin
                emit = 1'b1;
                if (count_reg == CNT_W'(DEPTH))
                begin
                    out_status_next = ST_OVERFLOW;
                end
                else
                begin
                    out_status_next = ST_OK;
                    ctl.cmd         = CELL_PUSH;
                    count_next      = count_reg + CNT_W'(1);
                end
            end
            else if (req.op == OP_POP)
            begin
                emit = 1'b1;
                if (count_reg == '0)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_status_next = ST_OK;
                    out_data_next   = cell_word[0];
                    ctl.cmd         = CELL_POP;
                    count_next      = count_reg - CNT_W'(1);
                end
            end
            else if (req.op == OP_DUMP)
            begin
                emit = 1'b1;
                if (count_reg == '0)
                begin
                    out_status_next = ST_EMPTY;
                end
                else
                begin
                    out_status_next = ST_OK;
                    out_data_next   = cell_word[0];
                    out_last_next   = (count_reg == CNT_W'(1));
                    ctl.cmd         = CELL_ROTATE;
                    remain_next     = count_reg - CNT_W'(1);
                    if (count_reg != CNT_W'(1))
                    begin
                        state_next = S_DUMP;
                    end
                end
            end
            else if (req.op == OP_PEEK)
            begin
                emit = 1'b1;
                if (bad_pos)
                begin
                    out_status_next = ST_BADPOS;
                end
                else
                begin
                    out_status_next = ST_OK;
                    out_data_next   = peek_data;
                end
            end
            else if (req.op == OP_CHANGE)
            begin
                emit = 1'b1;
                if (bad_pos)
                begin
                    out_status_next = ST_BADPOS;
                end
                else
                begin
                    out_status_next = ST_OK;
                    ctl.cmd         = CELL_WRITE;
                end
            end
        end
        else if ((state_reg == S_DUMP) && out_free)
        begin
            emit            = 1'b1;
            out_status_next = ST_OK;
            out_data_next   = cell_word[0];
            out_last_next   = (remain_reg == CNT_W'(1));
            ctl.cmd         = CELL_ROTATE;
            remain_next     = remain_reg - CNT_W'(1);
            if (remain_reg == CNT_W'(1))
            begin
                state_next = S_IDLE;
            end
        end
        else
        begin
            emit = 1'b0;
        end

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = out_status_reg;
    assign rsp.data   = out_data_reg;
    assign rsp.last   = out_last_reg;

    // Cell chain: cell 0 holds the top of the stack
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic signed [DATA_W-1:0] up_word;
        logic signed [DATA_W-1:0] down_word;

        if (g == 0)
        begin : g_first
            assign up_word = req.value;
        end
        else
        begin : g_mid_up
            assign up_word = cell_word[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_bottom
            assign down_word = '0;
        end
        else
        begin : g_mid_down
            assign down_word = cell_word[g+1];
        end

        lsc_cell #(
            .IDX (g)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .value     (req.value),
            .from_up   (up_word),
            .from_down (down_word),
            .top_word  (cell_word[0]),
            .word      (cell_word[g]),
            .peek      (cell_peek[g])
        );
    end

endmodule

// ===== rtl/lsc_cell.sv =====
// One storage cell of the stack chain: holds the word at depth IDX+1 from the top.
// Depends on lsc_pkg for the control struct and widths.
module lsc_cell
    import lsc_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic                     clk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] value,
    input  logic signed [DATA_W-1:0] from_up,
    input  logic signed [DATA_W-1:0] from_down,
    input  logic signed [DATA_W-1:0] top_word,
    output logic signed [DATA_W-1:0] word,
    output logic signed [DATA_W-1:0] peek
);

    logic signed [DATA_W-1:0] data_reg;
    logic signed [DATA_W-1:0] data_next;
    logic                     match;
    logic                     wrap;

    // Decode this cell's own position and wrap point
    assign match = (ctl.position == POS_W'(IDX + 1));
    assign wrap  = (ctl.wrap_idx == POS_W'(IDX));

    // Pick the next word from the neighbors or the request
    always_comb
    begin
        unique case (ctl.cmd)
            CELL_HOLD:   data_next = data_reg;
            CELL_PUSH:   data_next = from_up;
            CELL_POP:    data_next = from_down;
            CELL_ROTATE: data_next = wrap ? top_word : from_down;
            CELL_WRITE:  data_next = match ? value : data_reg;
            default:     data_next = data_reg;
        endcase
    end

    // Hold the word
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word = data_reg;
    assign peek = match ? data_reg : '0;

endmodule

// ===== rtl/lsc_checker.sv =====
// Port-level checks for the LIFO stack with peek and change, and the bind that attaches them.
// Depends on lsc_pkg and the top level lifo_stack_with_peek_change.
module lsc_checker
    import lsc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_ready,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic [STATUS_W-1:0]      rsp_status,
    input logic signed [DATA_W-1:0] rsp_data,
    input logic                     rsp_last
);

    // Hold a stalled response beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data) && $stable(rsp_last))
        else $error("response beat changed while stalled");

    // Keep requests out while a dump run is still being sent
    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> !req_ready)
        else $error("request taken in the middle of a dump run");

    // Carry no word on an error status
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ST_OK) |-> (rsp_data == '0))
        else $error("error status with nonzero data");

    // Only an ok dump beat may leave the run open
    a_open_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_last |-> (rsp_status == ST_OK))
        else $error("non-final beat with error status");

endmodule

bind lifo_stack_with_peek_change lsc_checker u_lsc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_status (rsp.status),
    .rsp_data   (rsp.data),
    .rsp_last   (rsp.last)
);

// ===== verif/lifo_stack_with_peek_change_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lifo_stack_with_peek_change: queue-fed driver, random stalls on
// both channels, and a shadow stack that predicts every response beat.
// Depends on lsc_pkg, lsc_if and the RTL of the stack.
module lifo_stack_with_peek_change_test;
    import lsc_pkg::*;

    localparam int STACK_DEPTH  = 64;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE_TICKS = 80;
    localparam int MAX_REPORTS  = 40;

    localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef struct {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] value;
        logic [POS_W-1:0]         position;
        bit                       drain_first;
    } stack_cmd_t;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } stack_rsp_t;

    logic clk;
    logic rst_n;

    lsc_req_if req_ch ();
    lsc_rsp_if rsp_ch ();

    lifo_stack_with_peek_change #(
        .DEPTH (STACK_DEPTH)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Commands waiting to go out, and the response beats they are known to cause
    stack_cmd_t pending_cmds[$];
    stack_rsp_t expected_rsps[$];

    // Shadow copy of the stack
    logic signed [DATA_W-1:0] shadow_words [STACK_DEPTH];
    int unsigned              shadow_count;

    // Run statistics
    int unsigned cmds_sent;
    int unsigned rsps_checked;
    int unsigned dumps_seen;
    int unsigned longest_dump;
    int unsigned overflows_seen;
    int unsigned empties_seen;
    int unsigned badpos_seen;
    int unsigned fail_count;
    int unsigned cycle_count;

    // Stimulus planning
    int unsigned plan_count;
    int unsigned random_cmds;
    bit          send_quiet;
    bit          recv_quiet;
    int          send_gap;
    int          recv_stall;

    // Free-running clock, 2 ns period
    always #1 clk = ~clk;

    // Gap length: mostly short, a few long, with quiet stretches of no gaps at all
    function automatic int pick_gap(inout bit quiet);
        int r;
        if ($urandom_range(0, 15) == 0)
            quiet = !quiet;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Advance the shadow stack by one accepted command and queue the beats it causes
    function automatic void predict_stack_op(logic [OP_W-1:0] op,
                                             logic signed [DATA_W-1:0] value,
                                             logic [POS_W-1:0] position);
        int slot;
        slot = (position == 0 || position > shadow_count) ? -1 :
               int'(shadow_count) - int'(position);
        case (op)
            OP_PUSH:
            begin
                if (shadow_count >= STACK_DEPTH)
                begin
                    expected_rsps.push_back('{ST_OVERFLOW, 32'sd0, 1'b1});
                    overflows_seen++;
                end
                else
                begin
                    shadow_words[shadow_count] = value;
                    shadow_count++;
                    expected_rsps.push_back('{ST_OK, 32'sd0, 1'b1});
                end
            end
            OP_POP:
            begin
                if (shadow_count == 0)
                begin
                    expected_rsps.push_back('{ST_EMPTY, 32'sd0, 1'b1});
                    empties_seen++;
                end
                else
                begin
                    shadow_count--;
                    expected_rsps.push_back('{ST_OK, shadow_words[shadow_count], 1'b1});
                end
            end
            OP_DUMP:
            begin
                dumps_seen++;
                if (shadow_count == 0)
                begin
                    expected_rsps.push_back('{ST_EMPTY, 32'sd0, 1'b1});
                    empties_seen++;
                end
                else
                begin
                    if (shadow_count > longest_dump)
                        longest_dump = shadow_count;
                    for (int k = 0; k < int'(shadow_count); k++)
                        expected_rsps.push_back('{ST_OK, shadow_words[shadow_count - 1 - k],
                                                  (k == int'(shadow_count) - 1)});
                end
            end
            OP_PEEK:
            begin
                if (slot < 0)
                begin
                    expected_rsps.push_back('{ST_BADPOS, 32'sd0, 1'b1});
                    badpos_seen++;
                end
                else
                    expected_rsps.push_back('{ST_OK, shadow_words[slot], 1'b1});
            end
            OP_CHANGE:
            begin
                if (slot < 0)
                begin
                    expected_rsps.push_back('{ST_BADPOS, 32'sd0, 1'b1});
                    badpos_seen++;
                end
                else
                begin
                    shadow_words[slot] = value;
                    expected_rsps.push_back('{ST_OK, 32'sd0, 1'b1});
                end
            end
            default:
            begin
                // spare op codes are swallowed with no response
            end
        endcase
    endfunction

    // Queue one command and track the occupancy it leaves behind
    task automatic add_cmd(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value,
                           logic [POS_W-1:0] position, bit drain_first);
        pending_cmds.push_back('{op, value, position, drain_first});
        if (op == OP_PUSH && plan_count < STACK_DEPTH)
            plan_count++;
        else if (op == OP_POP && plan_count > 0)
            plan_count--;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && plan_count > 0)
            return POS_W'($urandom_range(1, plan_count));
        else if (r < 7)
            return '0;
        else if (r < 8)
            return POS_W'(plan_count + 1);
        else
            return POS_W'($urandom_range(0, 127));
    endfunction

    // Random mix of all operations on a mostly shallow stack
    task automatic add_mixed(int n, bit drain_first);
        int               r;
        logic [OP_W-1:0]  op;
        bit               hold;
        hold = drain_first;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 32)
                op = (plan_count > 16) ? OP_POP : OP_PUSH;
            else if (r < 52)
                op = OP_POP;
            else if (r < 68)
                op = OP_PEEK;
            else if (r < 84)
                op = OP_CHANGE;
            else if (r < 92)
                op = OP_DUMP;
            else
                op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
            add_cmd(op, pick_word(), pick_position(), hold);
            hold = 1'b0;
            if (op <= OP_CHANGE)
                random_cmds++;
        end
    endtask

    // Fill to the brim, hit overflow, touch the bottom word, dump it all, then shrink a little
    task automatic add_fill();
        add_cmd(OP_PEEK, pick_word(), pick_position(), 1'b1);
        while (plan_count < STACK_DEPTH)
        begin
            add_cmd(OP_PUSH, pick_word(), '0, 1'b0);
            random_cmds++;
        end
        add_cmd(OP_PUSH, pick_word(), '0, 1'b0);
        add_cmd(OP_PUSH, pick_word(), '0, 1'b0);
        add_cmd(OP_PEEK, pick_word(), POS_W'(STACK_DEPTH), 1'b0);
        add_cmd(OP_CHANGE, pick_word(), POS_W'(STACK_DEPTH), 1'b0);
        add_cmd(OP_PEEK, pick_word(), POS_W'(STACK_DEPTH + 1), 1'b0);
        add_cmd(OP_DUMP, pick_word(), '0, 1'b0);
        add_cmd(OP_PEEK, pick_word(), 7'd1, 1'b0);
        random_cmds += 7;
        while (plan_count > STACK_DEPTH - 4)
        begin
            add_cmd(OP_POP, pick_word(), pick_position(), 1'b0);
            random_cmds++;
        end
    endtask

    // Request driver: hold a beat until taken, then launch the next after a random gap
    always @(posedge clk or negedge rst_n)
    begin
        stack_cmd_t next_cmd;
        bit         can_launch;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.op       <= '0;
            req_ch.value    <= '0;
            req_ch.position <= '0;
            send_gap = 0;
        end
        else
        begin
            can_launch = 1'b1;
            if (req_ch.valid && req_ch.ready)
            begin
                predict_stack_op(req_ch.op, req_ch.value, req_ch.position);
                cmds_sent++;
            end
            else if (req_ch.valid)
                can_launch = 1'b0;

            if (can_launch)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_cmds.size() > 0 &&
                         (!pending_cmds[0].drain_first || expected_rsps.size() == 0))
                begin
                    next_cmd = pending_cmds.pop_front();
                    req_ch.valid    <= 1'b1;
                    req_ch.op       <= next_cmd.op;
                    req_ch.value    <= next_cmd.value;
                    req_ch.position <= next_cmd.position;
                    send_gap = pick_gap(send_quiet);
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Response monitor: check each taken beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        stack_rsp_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsps_checked++;
                if (expected_rsps.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: unexpected response beat status=%0d data=%0d last=%0d",
                                 $time, rsp_ch.status, rsp_ch.data, rsp_ch.last);
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (rsp_ch.status !== want.status)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: status mismatch expected=%0d actual=%0d",
                                     $time, want.status, rsp_ch.status);
                    end
                    if (rsp_ch.data !== want.data)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: data mismatch expected=%0d actual=%0d",
                                     $time, want.data, rsp_ch.data);
                    end
                    if (rsp_ch.last !== want.last)
                    begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: last mismatch expected=%0d actual=%0d",
                                     $time, want.last, rsp_ch.last);
                    end
                end
                recv_stall = pick_gap(recv_quiet);
            end

            if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d beats still expected",
                     $time, expected_rsps.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        shadow_count    = 0;
        plan_count      = 0;
        random_cmds     = 0;
        fail_count      = 0;
        cycle_count     = 0;
        send_quiet      = 1'b0;
        recv_quiet      = 1'b0;

        // Directed: empty-stack cases, word extremes, bad positions, spare ops
        add_cmd(OP_POP,    pick_word(), '0, 1'b0);
        add_cmd(OP_DUMP,   pick_word(), '0, 1'b0);
        add_cmd(OP_PEEK,   pick_word(), 7'd1, 1'b0);
        add_cmd(OP_CHANGE, pick_word(), 7'd0, 1'b0);
        add_cmd(OP_PUSH,   WORD_MAX, '0, 1'b0);
        add_cmd(OP_PUSH,   WORD_MIN, '0, 1'b0);
        add_cmd(OP_PUSH,   32'sd0, '0, 1'b0);
        add_cmd(OP_PUSH,   -32'sd1, '0, 1'b0);
        add_cmd(OP_PEEK,   pick_word(), 7'd1, 1'b0);
        add_cmd(OP_PEEK,   pick_word(), 7'd4, 1'b0);
        add_cmd(OP_PEEK,   pick_word(), 7'd0, 1'b0);
        add_cmd(OP_PEEK,   pick_word(), 7'd5, 1'b0);
        add_cmd(OP_PEEK,   pick_word(), 7'd127, 1'b0);
        add_cmd(OP_CHANGE, 32'sh5A5A_5A5A, 7'd2, 1'b0);
        add_cmd(OP_CHANGE, pick_word(), 7'd5, 1'b0);
        add_cmd(OP_CHANGE, 32'sh8000_0001, 7'd4, 1'b0);
        add_cmd(OP_DUMP,   pick_word(), '0, 1'b0);
        add_cmd(OP_SPARE_5, pick_word(), POS_W'($urandom_range(0, 127)), 1'b0);
        add_cmd(OP_SPARE_6, pick_word(), POS_W'($urandom_range(0, 127)), 1'b0);
        add_cmd(OP_SPARE_7, pick_word(), POS_W'($urandom_range(0, 127)), 1'b0);
        add_cmd(OP_POP,    pick_word(), '0, 1'b0);
        add_cmd(OP_POP,    pick_word(), '0, 1'b0);
        add_cmd(OP_CHANGE, pick_word(), 7'd127, 1'b0);
        add_cmd(OP_DUMP,   pick_word(), '0, 1'b0);

        // Random: a shallow mix, one full fill, a short mix near the top, then a dump, a pop and a final dump
        while (random_cmds < 10)
            add_mixed(12, ($urandom_range(0, 2) == 0));
        add_fill();
        add_mixed(6, 1'b1);
        add_cmd(OP_DUMP, pick_word(), '0, 1'b1);
        add_cmd(OP_POP,  pick_word(), '0, 1'b0);
        add_cmd(OP_DUMP, pick_word(), '0, 1'b0);

        // Hold reset, then release it on a falling edge, away from the sampling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait until every command is out and every beat is back, then let the block settle
        while (pending_cmds.size() > 0 || req_ch.valid || expected_rsps.size() > 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);

        $display("Sent %0d commands, checked %0d response beats; %0d dumps, longest %0d words.",
                 cmds_sent, rsps_checked, dumps_seen, longest_dump);
        $display("Hit %0d overflows, %0d empty answers, %0d bad positions; %0d mismatches.",
                 overflows_seen, empties_seen, badpos_seen, fail_count);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
